@@ sv/mvsm_pkg.sv @@
package mvsm_pkg;

    // Default sizes of the block.
    localparam int DEF_MAX_VOICES    = 32;
    localparam int DEF_SAMPLE_WORDS  = 65536;
    localparam int DEF_NUM_SOURCES   = 8;
    localparam int DEF_FRACTION_BITS = 8;

    // Field widths fixed by the interface.
    localparam int WORD_W   = 16;
    localparam int LEN_W    = 17;
    localparam int CH_W     = 2;
    localparam int PITCH_W  = 16;
    localparam int SID_IN_W = 3;
    localparam int OP_W     = 3;

    // Largest stored length; longer lengths saturate at define.
    localparam logic [LEN_W-1:0] MAX_LENGTH = 17'h10000;

    // Operand width of the remainder unit: index plus channel count.
    localparam int DIV_W = 17;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_DEFINE = 3'd1,
        OP_PLAY   = 3'd2,
        OP_STOP   = 3'd3,
        OP_RENDER = 3'd4
    } op_t;

    // Handshake between the sequencer and the remainder unit.
    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

@@ sv/multi_voice_sample_mixer.sv @@
// Command-driven voice mixer. An item is taken when start is high and busy is low; its
// single result appears for exactly one cycle with done high, and the receiver cannot
// stall it. Load, define and play go straight to the result; stop reads and checks the
// voices one by one until it finds a match or reaches the last voice; a render walks every
// voice, and for each playing voice it waits on the bit-serial remainder unit (one bit of
// the 17-bit dividend per cycle) and uses the single sample memory read port (two reads
// per voice). Sample memory size is taken as a power of two. There is no clearing pass after reset.
module multi_voice_sample_mixer
    import mvsm_pkg::*;
#(
    parameter int MAX_VOICES    = DEF_MAX_VOICES,
    parameter int SAMPLE_WORDS  = DEF_SAMPLE_WORDS,
    parameter int NUM_SOURCES   = DEF_NUM_SOURCES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     operation,
    input  logic [15:0]         address,
    input  logic signed [15:0]  sample_value,
    input  logic [SID_IN_W-1:0] source_id,
    input  logic [15:0]         base,
    input  logic [LEN_W-1:0]    length,
    input  logic [CH_W-1:0]     channels,
    input  logic [PITCH_W-1:0]  pitch,
    input  logic                loops,
    output logic                done,
    output logic signed [15:0]  left_out,
    output logic signed [15:0]  right_out,
    output logic [5:0]          active_voices,
    output logic                status
);

    localparam int AW     = $clog2(SAMPLE_WORDS);
    localparam int SID_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int VI_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VOICES + 1);
    localparam int POS_W  = 16 + FRACTION_BITS;
    localparam int SH_L   = (FRACTION_BITS >= 8) ? FRACTION_BITS - 8 : 0;
    localparam int SH_R   = (FRACTION_BITS >= 8) ? 0 : 8 - FRACTION_BITS;
    localparam int STEP_W = 18 + SH_L;
    localparam int SUM_W  = (AW > 18) ? AW : 18;
    localparam int LD_W   = (AW > 16) ? AW : 16;

    typedef struct packed {
        logic [15:0]        base;
        logic [LEN_W-1:0]   len;
        logic [CH_W-1:0]    ch;
        logic [PITCH_W-1:0] pitch;
    } src_t;

    typedef struct packed {
        logic [SID_W-1:0] src;
        logic             loop;
        logic             playing;
        logic [POS_W-1:0] pos;
    } voice_t;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_STOP_RD  = 11'b00000000010,
        S_STOP_CHK = 11'b00000000100,
        S_V_RD     = 11'b00000001000,
        S_V_LD     = 11'b00000010000,
        S_V_SRC    = 11'b00000100000,
        S_DIV      = 11'b00001000000,
        S_RD0      = 11'b00010000000,
        S_RD1      = 11'b00100000000,
        S_ACC      = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    logic [15:0]        left_reg, left_next;
    logic [15:0]        right_reg, right_next;
    logic               status_reg, status_next;
    logic [SID_IN_W-1:0] sid_reg, sid_next;
    voice_t             v_reg, v_next;
    src_t               s_reg, s_next;

    // Storage.
    logic [15:0]        sample_mem [SAMPLE_WORDS];
    src_t               src_mem [NUM_SOURCES];
    voice_t             voice_mem [MAX_VOICES];
    logic [15:0]        s_rdata_reg;
    voice_t             v_rdata_reg;

    logic               smp_we;
    logic [AW-1:0]      smp_waddr, smp_raddr;
    logic               src_we;
    logic               v_we;
    logic [VI_W-1:0]    v_waddr, v_raddr;
    voice_t             v_wdata;

    div_ctl_t           div_ctl;
    logic [DIV_W-1:0]   div_dividend, div_divisor, div_rem;

    logic               accept;
    logic               sid_ok;
    logic [LEN_W-1:0]   len_sat;
    src_t               s_sel;
    logic [15:0]        idx;
    logic [SUM_W-1:0]   addr0, addr1;
    logic [17:0]        prod;
    logic [STEP_W-1:0]  step;
    logic [POS_W:0]     target, limit;
    logic               at_end;
    logic               last_voice;

    assign accept  = start && !busy;
    assign sid_ok  = 32'(source_id) < NUM_SOURCES;
    assign len_sat = (length > MAX_LENGTH) ? MAX_LENGTH : length;
    assign s_sel   = src_mem[v_reg.src];

    // Index of the next frame, cleared to an even word for stereo sources.
    always_comb
    begin
        idx = s_sel.ch > CH_W'(1) ? {v_reg.pos[POS_W-1:FRACTION_BITS+1], 1'b0}
                                  : v_reg.pos[POS_W-1:FRACTION_BITS];
    end
    assign div_dividend = DIV_W'(idx) + DIV_W'(s_sel.ch);
    assign div_divisor  = (s_sel.len == '0) ? DIV_W'(1) : DIV_W'(s_sel.len);
    assign div_ctl.start = (state_reg == S_V_SRC);

    mvsm_mod_unit #(
        .W (DIV_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_ctl.start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_ctl.done),
        .remainder (div_rem)
    );

    // Sample addresses wrap at the memory size.
    assign addr0 = SUM_W'(s_reg.base) + SUM_W'(div_rem);
    assign addr1 = addr0 + SUM_W'(1);

    // Position advance and end test.
    assign prod   = 18'(s_reg.ch) * 18'(s_reg.pitch);
    assign step   = (STEP_W'(prod) << SH_L) >> SH_R;
    assign target = (POS_W+1)'(v_reg.pos) + (POS_W+1)'(step);
    assign limit  = (s_reg.len <= LEN_W'(s_reg.ch)) ? '0
                  : ((POS_W+1)'(s_reg.len - LEN_W'(s_reg.ch)) << FRACTION_BITS);
    assign at_end = target >= limit;

    assign last_voice = (i_reg + CNT_W'(1)) == count_reg;

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        w_next      = w_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        status_next = status_reg;
        sid_next    = sid_reg;
        v_next      = v_reg;
        s_next      = s_reg;
        smp_we      = 1'b0;
        smp_waddr   = LD_W'(address) >> 0;
        smp_raddr   = addr0[AW-1:0];
        src_we      = 1'b0;
        v_we        = 1'b0;
        v_waddr     = count_reg[VI_W-1:0];
        v_raddr     = i_reg[VI_W-1:0];
        v_wdata     = v_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    left_next   = '0;
                    right_next  = '0;
                    status_next = 1'b0;
                    sid_next    = source_id;
                    i_next      = '0;
                    w_next      = '0;
                    state_next  = S_DONE;
                    unique case (operation)
                        OP_LOAD:
                        begin
                            smp_we = 1'b1;
                        end
                        OP_DEFINE:
                        begin
                            src_we = sid_ok;
                        end
                        OP_PLAY:
                        begin
                            if (count_reg >= CNT_W'(MAX_VOICES))
                            begin
                                status_next = 1'b1;
                            end
                            else if (sid_ok)
                            begin
                                v_we            = 1'b1;
                                v_wdata.src     = SID_W'(source_id);
                                v_wdata.loop    = loops;
                                v_wdata.playing = 1'b1;
                                v_wdata.pos     = '0;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        OP_STOP:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_STOP_RD;
                            end
                        end
                        OP_RENDER:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_V_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_STOP_RD:
            begin
                state_next = S_STOP_CHK;
            end
            S_STOP_CHK:
            begin
                if (8'(v_rdata_reg.src) == 8'(sid_reg))
                begin
                    v_we            = 1'b1;
                    v_waddr         = i_reg[VI_W-1:0];
                    v_wdata         = v_rdata_reg;
                    v_wdata.playing = 1'b0;
                    state_next      = S_DONE;
                end
                else if (last_voice)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_STOP_RD;
                end
            end
            S_V_RD:
            begin
                state_next = S_V_LD;
            end
            S_V_LD:
            begin
                v_next = v_rdata_reg;
                if (v_rdata_reg.playing)
                begin
                    state_next = S_V_SRC;
                end
                else if (last_voice)
                begin
                    count_next = w_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_V_RD;
                end
            end
            S_V_SRC:
            begin
                s_next     = s_sel;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_ctl.done)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                smp_raddr  = addr0[AW-1:0];
                state_next = S_RD1;
            end
            S_RD1:
            begin
                smp_raddr  = addr1[AW-1:0];
                left_next  = left_reg + s_rdata_reg;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                right_next = right_reg + s_rdata_reg;
                v_wdata    = v_reg;
                v_waddr    = w_reg[VI_W-1:0];
                if (at_end)
                begin
                    v_wdata.pos = '0;
                    v_we        = v_reg.loop;
                end
                else
                begin
                    v_wdata.pos = target[POS_W-1:0];
                    v_we        = 1'b1;
                end
                w_next = v_we ? w_reg + CNT_W'(1) : w_reg;
                if (last_voice)
                begin
                    count_next = w_next;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_V_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            w_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            w_reg     <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        right_reg  <= right_next;
        status_reg <= status_next;
        sid_reg    <= sid_next;
        v_reg      <= v_next;
        s_reg      <= s_next;
    end

    // Sample memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (smp_we)
        begin
            sample_mem[smp_waddr[AW-1:0]] <= sample_value;
        end
        s_rdata_reg <= sample_mem[smp_raddr];
    end

    // Source descriptors.
    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[SID_W'(source_id)] <= {base, len_sat, channels, pitch};
        end
    end

    // Voice table: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            voice_mem[v_waddr] <= v_wdata;
        end
        v_rdata_reg <= voice_mem[v_raddr];
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign left_out      = left_reg;
    assign right_out     = right_reg;
    assign active_voices = 6'(count_reg);
    assign status        = status_reg;

`ifndef SYNTHESIS
    // The voice count never exceeds the table size.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VOICES))
        else $error("voice count exceeds table size");

    // An accepted command always makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("command accepted without going busy");

    // A result strobe lasts exactly one cycle and frees the block.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not a single cycle");

    // Only a play can report a drop.
    a_status_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (count_reg == CNT_W'(MAX_VOICES)))
        else $error("drop reported with room in the table");
`endif

endmodule

@@ sv/mvsm_mod_unit.sv @@
module mvsm_mod_unit
    import mvsm_pkg::*;
#(
    parameter int W = DIV_W
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // One restoring step per cycle: shift in one dividend bit, subtract if it fits.
    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[W-1]};
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
            cnt_next = CW'(W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
